// ===== rtl/core/hte_pkg.sv =====
// Shared types and constants for the Huffman table encoder.
// No dependencies; imported by every module except hte_ram.
package hte_pkg;

    localparam int OP_W       = 2;
    localparam int SYM_W      = 8;
    localparam int LEN_W      = 6;
    localparam int CODE_MAX_W = 32;
    localparam int BYTE_W     = 8;

    localparam int HTE_MAX_CODE_BITS = 32;
    localparam int HTE_NUM_SYMBOLS   = 256;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_ENC   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ENC,
        CMD_FLUSH,
        CMD_ERR
    } t_cmd_kind;

    // One queued request for the packer.
    typedef struct packed {
        t_cmd_kind               kind;
        logic [LEN_W-1:0]        len;
        logic [CODE_MAX_W-1:0]   code;
    } t_cmd;

    // Usable code width: the length cap.
    function automatic int code_width(input int max_bits);
        code_width = (max_bits < CODE_MAX_W) ? max_bits : CODE_MAX_W;
    endfunction

endpackage

// ===== rtl/core/hte_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/hte_front.sv =====
// Front end: accepts requests, owns the code table, classifies each request.
// Depends on hte_pkg and hte_ram.
module hte_front #(
    parameter int MAX_CODE_BITS = hte_pkg::HTE_MAX_CODE_BITS,
    parameter int NUM_SYMBOLS   = hte_pkg::HTE_NUM_SYMBOLS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [hte_pkg::OP_W-1:0]     i_op,
    input  logic [hte_pkg::SYM_W-1:0]    i_symbol,
    input  logic [hte_pkg::LEN_W-1:0]    i_code_length,
    input  logic [hte_pkg::CODE_MAX_W-1:0] i_code_value,
    output logic                         o_push,
    output hte_pkg::t_cmd                o_cmd,
    input  logic                         i_q_ready
);
    import hte_pkg::*;

    localparam int CODE_W = code_width(MAX_CODE_BITS);
    localparam int ADDR_W = $clog2(NUM_SYMBOLS);
    localparam int ENT_W  = CODE_W + LEN_W;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CODE_W);

    logic              acc;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic              we;
    logic              re;
    logic [LEN_W-1:0]  len_cap;
    logic [ENT_W-1:0]  rdata;
    logic [LEN_W-1:0]  rd_len;
    logic              s1_free;

    logic r_vld [NUM_SYMBOLS];
    logic r_s1_valid, n_s1_valid;
    logic r_s1_flush, n_s1_flush;
    logic r_s1_hit,   n_s1_hit;

    assign addr     = i_symbol[ADDR_W-1:0];
    assign in_range = ({1'b0, i_symbol} < (SYM_W+1)'(NUM_SYMBOLS));
    assign s1_free  = !r_s1_valid || i_q_ready;
    assign o_ready  = s1_free;
    assign acc      = i_valid && s1_free;
    assign we       = acc && (i_op == OP_LOAD) && in_range;
    assign re       = acc && (i_op == OP_ENC);
    assign len_cap  = (i_code_length > LEN_CAP) ? LEN_CAP : i_code_length;

    hte_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SYMBOLS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (addr),
        .i_wdata ({len_cap, i_code_value[CODE_W-1:0]}),
        .i_re    (re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    // Valid bits reset to zero: an entry counts as having no code until loaded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SYMBOLS; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (we) begin
            r_vld[addr] <= 1'b1;
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid && !i_q_ready;
        n_s1_flush = r_s1_flush;
        n_s1_hit   = r_s1_hit;
        if (acc && ((i_op == OP_ENC) || (i_op == OP_FLUSH))) begin
            n_s1_valid = 1'b1;
            n_s1_flush = (i_op == OP_FLUSH);
            n_s1_hit   = in_range && r_vld[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
        r_s1_flush <= n_s1_flush;
        r_s1_hit   <= n_s1_hit;
    end

    assign rd_len = rdata[ENT_W-1 -: LEN_W];

    always_comb begin
        o_cmd.len  = rd_len;
        o_cmd.code = CODE_MAX_W'(rdata[CODE_W-1:0]);
        if (r_s1_flush) begin
            o_cmd.kind = CMD_FLUSH;
        end else if (r_s1_hit && (rd_len != '0)) begin
            o_cmd.kind = CMD_ENC;
        end else begin
            o_cmd.kind = CMD_ERR;
        end
    end

    assign o_push = r_s1_valid;

endmodule

// ===== rtl/core/hte_queue.sv =====
// Short request queue between front end and packer.
// Depends on hte_pkg.
module hte_queue #(
    parameter int DEPTH = hte_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hte_pkg::t_cmd i_cmd,
    output logic          o_ready,
    output logic          o_valid,
    output hte_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import hte_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/hte_back.sv =====
// Back end: bit packer with output register; one byte per cycle
// unless the output stalls. Depends on hte_pkg.
module hte_back #(
    parameter int MAX_CODE_BITS = hte_pkg::HTE_MAX_CODE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_valid,
    input  hte_pkg::t_cmd              i_cmd,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_kind,
    output logic [hte_pkg::BYTE_W-1:0] o_packed_byte,
    output logic                       o_last
);
    import hte_pkg::*;

    localparam int CODE_W = code_width(MAX_CODE_BITS);
    localparam int BUF_W  = CODE_W + BYTE_W - 1;
    localparam int TOT_W  = $clog2(BUF_W + 1);

    logic [BUF_W-1:0]  r_buf,   n_buf;
    logic [TOT_W-1:0]  r_total, n_total;
    logic              r_busy,  n_busy;
    logic              r_o_valid, n_o_valid;
    logic              r_o_kind,  n_o_kind;
    logic [BYTE_W-1:0] r_o_byte,  n_o_byte;
    logic              r_o_last,  n_o_last;

    logic              out_free;
    logic [TOT_W-1:0]  len_t;
    logic [TOT_W-1:0]  sum;
    logic [TOT_W-1:0]  sh;
    logic [BUF_W-1:0]  shifted;
    logic [6:0]        pend;
    logic [CODE_W-1:0] code_m;

    assign out_free = !r_o_valid || i_ready;
    assign len_t    = i_cmd.len[TOT_W-1:0];
    assign sum      = r_total + len_t;
    assign sh       = r_total - TOT_W'(BYTE_W);
    assign shifted  = r_buf >> sh;
    // pending bits are the low r_total bits while not busy
    assign pend     = r_buf[6:0] & ~(7'h7F << r_total[2:0]);
    assign code_m   = i_cmd.code[CODE_W-1:0] & ~({CODE_W{1'b1}} << len_t);

    always_comb begin
        n_buf     = r_buf;
        n_total   = r_total;
        n_busy    = r_busy;
        n_o_valid = r_o_valid && !i_ready;
        n_o_kind  = r_o_kind;
        n_o_byte  = r_o_byte;
        n_o_last  = r_o_last;
        o_pop     = 1'b0;
        if (r_busy) begin
            if (out_free) begin
                n_o_valid = 1'b1;
                n_o_kind  = KIND_BYTE;
                n_o_byte  = shifted[BYTE_W-1:0];
                n_o_last  = (sh < TOT_W'(BYTE_W));
                n_busy    = !n_o_last;
                n_total   = sh;
            end
        end else if (i_q_valid) begin
            unique case (i_cmd.kind)
                CMD_ENC: begin
                    o_pop   = 1'b1;
                    n_buf   = (BUF_W'(pend) << len_t) | BUF_W'(code_m);
                    n_total = sum;
                    n_busy  = (sum >= TOT_W'(BYTE_W));
                end
                CMD_FLUSH: begin
                    if (r_total == '0) begin
                        o_pop = 1'b1;
                    end else if (out_free) begin
                        o_pop     = 1'b1;
                        n_o_valid = 1'b1;
                        n_o_kind  = KIND_BYTE;
                        n_o_byte  = {pend, 1'b0} << (3'd7 - r_total[2:0]);
                        n_o_last  = 1'b1;
                        n_total   = '0;
                    end
                end
                CMD_ERR: begin
                    if (out_free) begin
                        o_pop     = 1'b1;
                        n_o_valid = 1'b1;
                        n_o_kind  = KIND_ERR;
                        n_o_byte  = '0;
                        n_o_last  = 1'b1;
                    end
                end
                default: begin
                    o_pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_total   <= n_total;
            r_busy    <= n_busy;
            r_o_valid <= n_o_valid;
        end
        r_buf    <= n_buf;
        r_o_kind <= n_o_kind;
        r_o_byte <= n_o_byte;
        r_o_last <= n_o_last;
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_packed_byte = r_o_byte;
    assign o_last        = r_o_last;

endmodule

// ===== rtl/core/huffman_table_encoder.sv =====
// Table-driven Huffman encoder with byte packer: top level.
// Throughput: front takes a request every cycle while the queue has room;
// the packer takes no new request while an encode still has bytes to emit;
// loads never reach the packer.
// Sync active-low reset clears table valid bits, pending bits, queue, output.
// Depends on hte_pkg, hte_front, hte_queue, hte_back, hte_ram.
module huffman_table_encoder #(
    parameter int MAX_CODE_BITS = hte_pkg::HTE_MAX_CODE_BITS,
    parameter int NUM_SYMBOLS   = hte_pkg::HTE_NUM_SYMBOLS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [hte_pkg::OP_W-1:0]       i_op,
    input  logic [hte_pkg::SYM_W-1:0]      i_symbol,
    input  logic [hte_pkg::LEN_W-1:0]      i_code_length,
    input  logic [hte_pkg::CODE_MAX_W-1:0] i_code_value,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic                           o_kind,
    output logic [hte_pkg::BYTE_W-1:0]     o_packed_byte,
    output logic                           o_last
);
    import hte_pkg::*;

    // front -> queue
    logic push;
    t_cmd front_cmd;
    logic q_ready;
    // queue -> back
    logic q_valid;
    t_cmd q_cmd;
    logic pop;

    // Front: load writes, encode reads table; one request a cycle unless full.
    hte_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .NUM_SYMBOLS   (NUM_SYMBOLS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .i_code_value  (i_code_value),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .i_q_ready     (q_ready)
    );

    // Queue soaks up multi-byte codes so the front keeps taking requests.
    hte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (pop)
    );

    // Back: packs code bits MSB first, emits one byte per cycle via a
    // registered output stage while the result channel is not stalled.
    hte_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (q_cmd),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_packed_byte (o_packed_byte),
        .o_last        (o_last)
    );

endmodule

// ===== dv/huffman_table_encoder_tb.sv =====
// Self-checking testbench for the Huffman table encoder and its byte packer.
// Depends on hte_pkg and huffman_table_encoder; a queue-fed driver, a checking
// monitor and an in-bench predictor of the code table and bit buffer.
module huffman_table_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hte_pkg::*;

    // op code 3 has no meaning; the block must swallow it
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int N_SYMS   = HTE_NUM_SYMBOLS;
    localparam int LEN_CAP  = (HTE_MAX_CODE_BITS < CODE_MAX_W) ? HTE_MAX_CODE_BITS
                                                               : CODE_MAX_W;
    localparam int N_RANDOM = 370;
    // slowest legal run: ~410 requests, longest gaps, every byte stalled, x3
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [OP_W-1:0]       op;
        logic [SYM_W-1:0]      sym;
        logic [LEN_W-1:0]      len;
        logic [CODE_MAX_W-1:0] code;
    } t_enc_req;

    typedef struct {
        logic              kind;
        logic [BYTE_W-1:0] packed_byte;
        logic              last;
    } t_packed_res;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [OP_W-1:0]       i_op = OP_LOAD;
    logic [SYM_W-1:0]      i_symbol = '0;
    logic [LEN_W-1:0]      i_code_length = '0;
    logic [CODE_MAX_W-1:0] i_code_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_kind;
    logic [BYTE_W-1:0]     o_packed_byte;
    logic                  o_last;

    huffman_table_encoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_symbol      (i_symbol),
        .i_code_length (i_code_length),
        .i_code_value  (i_code_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_packed_byte (o_packed_byte),
        .o_last        (o_last)
    );

    // Requests waiting to go out, and bytes/errors the block still owes us.
    t_enc_req    req_q[$];
    t_packed_res byte_q[$];

    // Shadow of the encoder state.
    logic [LEN_W-1:0]      len_tbl  [N_SYMS];
    logic [CODE_MAX_W-1:0] code_tbl [N_SYMS];
    logic [6:0]            pend_bits;
    int                    pend_cnt;

    int n_errors    = 0;
    int n_accepted  = 0;
    int n_results   = 0;
    int n_no_code   = 0;
    int n_flushed   = 0;
    int cycles      = 0;

    // Driver and receiver idling state.
    int tx_gap  = 0;
    int tx_calm = 0;
    int rx_hold = 0;
    int rx_calm = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Lengths: mostly short codes, some up to the cap, a few overlong, a few
    // with no code at all.
    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)  return '0;
        if (r < 70) return LEN_W'($urandom_range(1, 12));
        if (r < 90) return LEN_W'($urandom_range(13, 32));
        return LEN_W'($urandom_range(33, 63));
    endfunction

    task automatic add_req(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [LEN_W-1:0] len, input logic [CODE_MAX_W-1:0] code);
        t_enc_req rq;
        rq.op   = op;
        rq.sym  = sym;
        rq.len  = len;
        rq.code = code;
        req_q.push_back(rq);
    endtask

    task automatic owe(input logic kind, input logic [BYTE_W-1:0] b, input logic last);
        t_packed_res pr;
        pr.kind        = kind;
        pr.packed_byte = b;
        pr.last        = last;
        byte_q.push_back(pr);
    endtask

    // Work out what one accepted request makes the block emit. Completed bytes
    // are held back by one so that the final one can carry last.
    task automatic pack_request(input t_enc_req rq);
        logic [7:0]            acc;
        logic [7:0]            held;
        logic [CODE_MAX_W-1:0] code;
        bit                    have_held;
        int                    clen;
        int                    cnt;
        acc       = {1'b0, pend_bits};
        held      = '0;
        have_held = 1'b0;
        cnt       = pend_cnt;
        case (rq.op)
            OP_LOAD: begin
                if (int'(rq.sym) < N_SYMS) begin
                    code_tbl[rq.sym] = rq.code;
                    len_tbl[rq.sym]  = (int'(rq.len) > LEN_CAP) ? LEN_W'(LEN_CAP) : rq.len;
                end
            end
            OP_ENC: begin
                clen = (int'(rq.sym) < N_SYMS) ? int'(len_tbl[rq.sym]) : 0;
                if (clen == 0) begin
                    // no code for this symbol: dropped, buffer untouched
                    owe(KIND_ERR, '0, 1'b1);
                    n_no_code++;
                end else begin
                    code = code_tbl[rq.sym];
                    for (int i = clen; i > 0; i--) begin
                        acc = {acc[6:0], code[i-1]};
                        cnt++;
                        if (cnt == 8) begin
                            if (have_held) owe(KIND_BYTE, held, 1'b0);
                            held      = acc;
                            have_held = 1'b1;
                            acc       = '0;
                            cnt       = 0;
                        end
                    end
                    if (have_held) owe(KIND_BYTE, held, 1'b1);
                    pend_bits = acc[6:0];
                    pend_cnt  = cnt;
                end
            end
            OP_FLUSH: begin
                if (pend_cnt > 0) begin
                    // pad the tail on the low end with zeros
                    owe(KIND_BYTE, 8'({1'b0, pend_bits} << (8 - pend_cnt)), 1'b1);
                    n_flushed++;
                end
                pend_bits = '0;
                pend_cnt  = 0;
            end
            default: ;
        endcase
    endtask

    // Driver: holds a request until it is taken, then pops the next one after
    // an optional gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                pack_request('{i_op, i_symbol, i_code_length, i_code_value});
                n_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    i_op          <= req_q[0].op;
                    i_symbol      <= req_q[0].sym;
                    i_code_length <= req_q[0].len;
                    i_code_value  <= req_q[0].code;
                    i_valid       <= 1'b1;
                    void'(req_q.pop_front());
                    // occasional stretch with no pauses at all
                    if (tx_calm > 0) tx_calm--;
                    else if ($urandom_range(0, 99) < 3) tx_calm = $urandom_range(15, 40);
                    tx_gap = (tx_calm > 0) ? 0 : pick_gap();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every result against the oldest one owed, and throttles
    // the result channel with random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                n_results++;
                if (byte_q.size() == 0) begin
                    $display("%0t: unexpected result kind=%0b byte=%02h last=%0b",
                             $realtime, o_kind, o_packed_byte, o_last);
                    n_errors++;
                end else begin
                    if (o_kind !== byte_q[0].kind) begin
                        $display("%0t: kind mismatch, expected %0b got %0b",
                                 $realtime, byte_q[0].kind, o_kind);
                        n_errors++;
                    end
                    if (o_packed_byte !== byte_q[0].packed_byte) begin
                        $display("%0t: byte mismatch, expected %02h got %02h",
                                 $realtime, byte_q[0].packed_byte, o_packed_byte);
                        n_errors++;
                    end
                    if (o_last !== byte_q[0].last) begin
                        $display("%0t: last mismatch, expected %0b got %0b",
                                 $realtime, byte_q[0].last, o_last);
                        n_errors++;
                    end
                    void'(byte_q.pop_front());
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (rx_calm > 0) rx_calm--;
                else if ($urandom_range(0, 199) < 3) rx_calm = $urandom_range(20, 60);
                else if ($urandom_range(0, 99) < 25) rx_hold = pick_gap();
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timed out, %0d requests left, %0d results owed",
                     $realtime, req_q.size(), byte_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int             known[$];
        int             counted;
        int             r;
        logic [LEN_W-1:0] len;
        logic [SYM_W-1:0] sym;

        for (int i = 0; i < N_SYMS; i++) begin
            len_tbl[i]  = '0;
            code_tbl[i] = '0;
        end
        pend_bits = '0;
        pend_cnt  = 0;

        // Directed part.
        add_req(OP_ENC,   8'd5,   6'd0,  32'h0000_0000); // empty table: no code
        add_req(OP_FLUSH, 8'd0,   6'd0,  32'h0000_0000); // flush, nothing pending
        add_req(OP_SPARE, 8'hFF,  6'h3F, 32'hFFFF_FFFF); // unused op
        add_req(OP_LOAD,  8'd0,   6'd1,  32'hFFFF_FFFF); // bits above length ignored
        add_req(OP_LOAD,  8'd255, 6'd32, 32'hA5C3_0F96); // full-width code
        add_req(OP_LOAD,  8'd128, 6'd63, 32'h8000_0001); // overlong, saturates
        add_req(OP_LOAD,  8'd7,   6'd8,  32'h1234_565A);
        add_req(OP_LOAD,  8'd9,   6'd0,  32'hDEAD_BEEF); // loaded with no code
        add_req(OP_LOAD,  8'd3,   6'd33, 32'h0000_0000); // saturates, all-zero code
        add_req(OP_LOAD,  8'd1,   6'd7,  32'h0000_007F);
        add_req(OP_ENC,   8'd0,   6'd0,  32'h0000_0000); // one bit, no byte yet
        add_req(OP_FLUSH, 8'd0,   6'd0,  32'h0000_0000); // single padded byte
        add_req(OP_ENC,   8'd255, 6'd0,  32'h0000_0000); // four bytes at once
        add_req(OP_ENC,   8'd0,   6'd0,  32'h0000_0000);
        add_req(OP_ENC,   8'd128, 6'd0,  32'h0000_0000); // 33 bits over the edge
        add_req(OP_ENC,   8'd7,   6'd0,  32'h0000_0000);
        add_req(OP_ENC,   8'd9,   6'd0,  32'h0000_0000); // no code, buffer kept
        add_req(OP_FLUSH, 8'd0,   6'd0,  32'h0000_0000);
        add_req(OP_ENC,   8'd1,   6'd0,  32'h0000_0000); // seven pending
        add_req(OP_ENC,   8'd3,   6'd0,  32'h0000_0000); // 39 bits, worst burst
        add_req(OP_ENC,   8'd1,   6'd0,  32'h0000_0000);
        add_req(OP_SPARE, 8'd0,   6'd0,  32'h0000_0000);
        add_req(OP_FLUSH, 8'd0,   6'd0,  32'h0000_0000);
        known = '{0, 255, 128, 7, 3, 1};

        // Random part: fill part of the table first, then mostly encodes of
        // loaded symbols mixed with reloads, flushes and noise.
        for (int i = 0; i < 40; i++) begin
            sym = SYM_W'($urandom_range(0, 255));
            len = pick_len();
            add_req(OP_LOAD, sym, len, $urandom());
            if (len != 0) known.push_back(int'(sym));
        end
        counted = 40;
        while (counted < N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                sym = SYM_W'($urandom_range(0, 255));
                len = pick_len();
                add_req(OP_LOAD, sym, len, $urandom());
                if (len != 0) known.push_back(int'(sym));
                counted++;
            end else if (r < 80) begin
                if ($urandom_range(0, 9) != 0)
                    sym = SYM_W'(known[$urandom_range(0, known.size() - 1)]);
                else
                    sym = SYM_W'($urandom_range(0, 255));
                // spare fields carry junk on an encode
                add_req(OP_ENC, sym, LEN_W'($urandom()), $urandom());
                counted++;
            end else if (r < 95) begin
                add_req(OP_FLUSH, SYM_W'($urandom()), LEN_W'($urandom()), $urandom());
                counted++;
            end else begin
                add_req(OP_SPARE, SYM_W'($urandom()), LEN_W'($urandom()), $urandom());
            end
        end
        add_req(OP_FLUSH, 8'd0, 6'd0, 32'h0000_0000);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_q.size() > 0 || i_valid) @(posedge i_clk);
        while (byte_q.size() > 0) @(posedge i_clk);
        // let any stray output surface before the verdict
        repeat (20) @(posedge i_clk);

        $display("Covered %0d requests (directed corner cases then random table and stream mix)",
                 n_accepted);
        $display("Checked %0d results: %0d no-code errors, %0d flush bytes, %0d mismatches",
                 n_results, n_no_code, n_flushed, n_errors);
        if (n_errors == 0 && byte_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== huffman_table_encoder.f =====
rtl/core/hte_pkg.sv
rtl/core/hte_ram.sv
rtl/core/hte_front.sv
rtl/core/hte_queue.sv
rtl/core/hte_back.sv
rtl/core/huffman_table_encoder.sv
dv/huffman_table_encoder_tb.sv
